// ===== rtl/spr_pkg.sv =====
// Shared types and constants for the stream pattern replace block.
// No dependencies; imported by the cell, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package spr_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_PATTERN_LENGTH    = t_cfg_idx'(0);
    localparam t_cfg_idx REG_PATTERN_BYTES     = t_cfg_idx'(1);
    localparam t_cfg_idx REG_REPLACEMENT_BYTES = t_cfg_idx'(2);

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_NEAR,
        CELL_FAR,
        CELL_LOAD
    } t_cell_sel;

endpackage

// ===== rtl/spr_cell.sv =====
// One window cell: holds a text byte, compares it with its pattern byte
// and takes its next byte from a neighbor or the input. Uses spr_pkg.
`timescale 1ns / 1ps

module spr_cell
    import spr_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_sel         i_sel,
    input  logic [BYTE_W-1:0] i_near,
    input  logic [BYTE_W-1:0] i_far,
    input  logic [BYTE_W-1:0] i_text,
    input  logic [BYTE_W-1:0] i_pat_byte,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_hit
);

    logic [BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        case (i_sel)
            CELL_HOLD: r_byte <= r_byte;
            CELL_NEAR: r_byte <= i_near;
            CELL_FAR:  r_byte <= i_far;
            CELL_LOAD: r_byte <= i_text;
            default:   r_byte <= r_byte;
        endcase
    end

    assign o_byte = r_byte;
    assign o_hit  = (r_byte == i_pat_byte);

endmodule

// ===== rtl/spr_out_queue.sv =====
// Output queue: takes up to LANES bytes in one cycle and hands out one
// beat per cycle while i_stall is low. Standalone; no package needed.
`timescale 1ns / 1ps

module spr_out_queue #(
    parameter  int LANES = 8,
    parameter  int DEPTH = 16,
    localparam int LW    = $clog2(LANES + 1),
    localparam int PW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LW-1:0]    i_push_n,
    input  logic [7:0]       i_bytes [LANES],
    input  logic [LANES-1:0] i_lasts,
    output logic [CW-1:0]    o_free,
    output logic             o_valid,
    output logic [7:0]       o_byte,
    output logic             o_last,
    input  logic             i_stall
);

    logic [7:0]    r_data [DEPTH];
    logic          r_last [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_byte  = r_data[r_rd];
    assign o_last  = r_last[r_rd];
    assign o_free  = CW'(DEPTH) - r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push_n);
            r_rd    <= r_rd + PW'(pop);
            r_count <= r_count + CW'(i_push_n) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            if (LW'(k) < i_push_n) begin
                r_data[r_wr + PW'(k)] <= i_bytes[k];
                r_last[r_wr + PW'(k)] <= i_lasts[k];
            end
        end
    end

endmodule

// ===== rtl/stream_pattern_replace_unit.sv =====
// Top level of the stream pattern replace block: configuration registers,
// the row of window cells and the output queue. Uses spr_pkg, spr_cell,
// spr_out_queue.
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_stall     i_text_byte, i_final_byte
//   out       output     o_out_valid / i_out_stall   o_out_byte, o_out_last
//   cfg       input      i_cfg_we                    i_cfg_idx, i_cfg_data
//
// A byte enters the cell row in the cycle it is accepted and is compared in
// the next cycle, when the next byte may already enter: one byte per cycle
// unless stalled. After a length change, a window longer than the length
// stalls input for further checks. The output queue holds 2 * MAX_PATTERN
// beats, rounded up to a power of two; input stalls while the bytes of the
// pending check do not fit. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps

module stream_pattern_replace_unit
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_text_byte,
    input  logic                  i_final_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic                  o_out_last
);

    localparam int N  = MAX_PATTERN;
    localparam int LW = $clog2(N + 1);
    localparam int QD = 2 ** $clog2(2 * N);
    localparam int CW = $clog2(QD + 1);

    logic [LEN_REG_W-1:0]  r_pattern_length;
    logic [CFG_DATA_W-1:0] r_pattern_bytes;
    logic [CFG_DATA_W-1:0] r_replacement_bytes;

    logic [LW-1:0] r_held;
    logic [LW-1:0] n_held;
    logic          r_busy;
    logic          n_busy;
    logic          r_fin;
    logic          n_fin;

    logic [LW-1:0]       len;
    logic [BYTE_W-1:0]   cell_byte [N];
    logic [N-1:0]        cell_hit;
    logic [N-1:0]        hit_ok;
    t_cell_sel           cell_sel [N];
    logic [N*BYTE_W-1:0] win_flat;
    logic [N*BYTE_W-1:0] win_near;
    logic [N*BYTE_W-1:0] win_far;

    logic          match;
    logic          iterate;
    logic [LW-1:0] drop_n;
    logic [LW-1:0] held_left;
    logic          finish;
    logic          flush;
    logic [LW-1:0] push_n;
    logic [CW-1:0] q_free;
    logic          step_en;
    logic          can_take;
    logic          in_accept;
    logic [LW-1:0] base_held;

    logic [BYTE_W-1:0] em_byte [N];
    logic [N-1:0]      em_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length    <= LEN_REG_W'(1);
            r_pattern_bytes     <= '0;
            r_replacement_bytes <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PATTERN_LENGTH:    r_pattern_length    <= i_cfg_data[LEN_REG_W-1:0];
                REG_PATTERN_BYTES:     r_pattern_bytes     <= i_cfg_data;
                REG_REPLACEMENT_BYTES: r_replacement_bytes <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_pattern_length == '0) begin
            len = LW'(1);
        end else if (r_pattern_length > LEN_REG_W'(N)) begin
            len = LW'(N);
        end else begin
            len = LW'(r_pattern_length);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        assign win_flat[k*BYTE_W +: BYTE_W] = cell_byte[k];
        assign hit_ok[k] = cell_hit[k] || !(LW'(k) < len);

        spr_cell u_cell (
            .i_clk      (i_clk),
            .i_sel      (cell_sel[k]),
            .i_near     (win_near[k*BYTE_W +: BYTE_W]),
            .i_far      (win_far[k*BYTE_W +: BYTE_W]),
            .i_text     (i_text_byte),
            .i_pat_byte (r_pattern_bytes[k*BYTE_W +: BYTE_W]),
            .o_byte     (cell_byte[k]),
            .o_hit      (cell_hit[k])
        );
    end

    assign win_near = win_flat >> BYTE_W;
    assign win_far  = win_flat >> {len, 3'b000};

    assign match     = &hit_ok;
    assign iterate   = r_busy && (r_held >= len);
    assign drop_n    = iterate ? (match ? len : LW'(1)) : '0;
    assign held_left = r_held - drop_n;
    assign finish    = r_busy && (held_left < len);
    assign flush     = finish && r_fin;
    assign push_n    = !r_busy ? '0 : (flush ? r_held : drop_n);
    assign step_en   = r_busy && (CW'(push_n) <= q_free);
    assign can_take  = !r_busy || (step_en && finish);
    assign in_accept = i_in_valid && can_take;
    assign o_in_stall = !can_take;

    always_comb begin
        if (step_en) begin
            base_held = flush ? '0 : held_left;
        end else begin
            base_held = r_held;
        end
        n_held = in_accept ? base_held + LW'(1) : base_held;
        if (in_accept) begin
            n_busy = 1'b1;
            n_fin  = i_final_byte;
        end else begin
            n_busy = (step_en && finish) ? 1'b0 : r_busy;
            n_fin  = r_fin;
        end
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (in_accept && (LW'(k) == base_held)) begin
                cell_sel[k] = CELL_LOAD;
            end else if (step_en && iterate && !flush) begin
                cell_sel[k] = match ? CELL_FAR : CELL_NEAR;
            end else begin
                cell_sel[k] = CELL_HOLD;
            end
        end
    end

    // The emitted bytes line up with the cell positions: a match replaces
    // the first len cells and every other beat is the cell byte itself.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (iterate && match && (LW'(k) < len)) begin
                em_byte[k] = r_replacement_bytes[k*BYTE_W +: BYTE_W];
            end else begin
                em_byte[k] = cell_byte[k];
            end
            em_last[k] = flush && (LW'(k + 1) == push_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_held <= n_held;
            r_busy <= n_busy;
            r_fin  <= n_fin;
        end
    end

    spr_out_queue #(
        .LANES (N),
        .DEPTH (QD)
    ) u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (step_en ? push_n : '0),
        .i_bytes  (em_byte),
        .i_lasts  (em_last),
        .o_free   (q_free),
        .o_valid  (o_out_valid),
        .o_byte   (o_out_byte),
        .o_last   (o_out_last),
        .i_stall  (i_out_stall)
    );

endmodule

// ===== rtl/spr_checker.sv =====
// Port-level checks for the stream pattern replace block, attached to the
// top level by the bind statement at the end of this file.
`timescale 1ns / 1ps

module spr_checker
    import spr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_out_last
);

    // A stalled output beat keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_out_last))
        else $error("output beat changed while stalled");

    // Reset leaves the output queue empty.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Reset leaves the block ready for the first input beat.
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind stream_pattern_replace_unit spr_checker u_spr_checker (.*);

// ===== sim/tb_stream_pattern_replace_unit.sv =====
// Self-checking testbench for stream_pattern_replace_unit: directed table, then random text
// with random idle and stall on both channels. Each output beat is checked by table or predictor.
// Depends on rtl/spr_pkg.sv and rtl/stream_pattern_replace_unit.sv.
`timescale 1ns / 1ps

module tb_stream_pattern_replace_unit;
    import spr_pkg::*;

    localparam int       WINDOW_DEPTH  = 8;
    localparam int       SETTLE_CYCLES = 16;
    localparam int       HOLD_CYCLES   = 300;
    localparam int       CYCLE_LIMIT   = 400000;
    localparam int       NUM_PHASES    = 8;
    localparam int       PRESSURE_PHASE = 4;
    localparam int       PAUSE_PHASE   = 6;
    localparam int       PHASE_BEATS   = 6;
    localparam int       PRESSURE_BEATS = 32;
    localparam t_cfg_idx REG_UNMAPPED  = t_cfg_idx'(3);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_text_beat;

    typedef enum logic {
        ROW_WRITE,
        ROW_BEAT
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
        logic [BYTE_W-1:0]     text;
        logic                  fin;
        logic                  typed;
        logic [BYTE_W-1:0]     exp_byte;
        logic                  exp_last;
    } t_row;

    localparam int DIRECTED_LEN = 29;

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    t_cfg_idx              i_cfg_idx    = REG_PATTERN_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_text_byte  = '0;
    logic                  i_final_byte = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_out_last;

    // Shadow of the block: configuration, window and its fill level.
    logic [LEN_REG_W-1:0]  len_reg;
    logic [CFG_DATA_W-1:0] pat_reg;
    logic [CFG_DATA_W-1:0] rep_reg;
    logic [BYTE_W-1:0]     shadow_window [WINDOW_DEPTH];
    int                    shadow_held;
    t_text_beat            step_out [WINDOW_DEPTH];

    t_text_beat expected_text [$];
    int         mismatches    = 0;
    int         cycle_count   = 0;
    int         beats_sent    = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_trigger  = 1'b0;
    logic       holding       = 1'b0;

    t_row directed_rows [DIRECTED_LEN] = '{
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h00, 0, 1, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'hFF, 1, 1, 8'hFF, 1},
        '{ROW_WRITE, REG_PATTERN_LENGTH,    64'hFFFFFFFFFFFFFFFF,  8'h00, 0, 0, 8'h00, 0},
        '{ROW_WRITE, REG_PATTERN_BYTES,     64'h00FF00FF00FF00FF,  8'h00, 0, 0, 8'h00, 0},
        '{ROW_WRITE, REG_REPLACEMENT_BYTES, 64'h8040201008040201,  8'h00, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'hFF, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h00, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'hFF, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h00, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'hFF, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h00, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'hFF, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h00, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h41, 1, 1, 8'h41, 1},
        '{ROW_WRITE, REG_PATTERN_LENGTH,    64'h0,                 8'h00, 0, 0, 8'h00, 0},
        '{ROW_WRITE, REG_PATTERN_BYTES,     64'h0123456789ABCD41,  8'h00, 0, 0, 8'h00, 0},
        '{ROW_WRITE, REG_REPLACEMENT_BYTES, 64'hFEDCBA987654325A,  8'h00, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h41, 1, 1, 8'h5A, 1},
        '{ROW_WRITE, REG_UNMAPPED,          64'h5555AAAA5555AAAA,  8'h00, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h41, 1, 1, 8'h5A, 1},
        '{ROW_WRITE, REG_PATTERN_LENGTH,    64'h4,                 8'h00, 0, 0, 8'h00, 0},
        '{ROW_WRITE, REG_PATTERN_BYTES,     64'h0000000064636261,  8'h00, 0, 0, 8'h00, 0},
        '{ROW_WRITE, REG_REPLACEMENT_BYTES, 64'h000000005A595857,  8'h00, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h61, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h62, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h63, 0, 0, 8'h00, 0},
        '{ROW_WRITE, REG_PATTERN_LENGTH,    64'h2,                 8'h00, 0, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h64, 1, 0, 8'h00, 0},
        '{ROW_BEAT,  REG_PATTERN_LENGTH,    64'h0,                 8'h7E, 1, 0, 8'h00, 0}
    };

    stream_pattern_replace_unit #(
        .MAX_PATTERN (WINDOW_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int active_length();
        int l;
        l = len_reg;
        if (l < 1) l = 1;
        if (l > WINDOW_DEPTH) l = WINDOW_DEPTH;
        return l;
    endfunction

    function automatic void shift_window(input int count);
        int k;
        for (k = 0; k + count < shadow_held; k++) shadow_window[k] = shadow_window[k + count];
        for (; k < WINDOW_DEPTH; k++) shadow_window[k] = '0;
        shadow_held = shadow_held - count;
    endfunction

    function automatic void clear_shadow();
        len_reg = LEN_REG_W'(1);
        pat_reg = '0;
        rep_reg = '0;
        shadow_held = 0;
        for (int k = 0; k < WINDOW_DEPTH; k++) shadow_window[k] = '0;
    endfunction

    // Returns the number of rewritten beats that one text byte releases, in step_out.
    function automatic int rewrite_step(input logic [BYTE_W-1:0] b, input logic fin);
        int   n;
        int   len;
        int   k;
        logic hit;
        n = 0;
        len = active_length();
        shadow_window[shadow_held] = b;
        shadow_held = shadow_held + 1;
        while (shadow_held >= len) begin
            hit = 1'b1;
            for (k = 0; k < len; k++) begin
                if (shadow_window[k] != pat_reg[8*k +: 8]) hit = 1'b0;
            end
            if (hit) begin
                for (k = 0; k < len; k++) begin
                    step_out[n] = '{data: rep_reg[8*k +: 8], last: 1'b0};
                    n = n + 1;
                end
                shift_window(len);
            end else begin
                step_out[n] = '{data: shadow_window[0], last: 1'b0};
                n = n + 1;
                shift_window(1);
            end
        end
        if (fin) begin
            for (k = 0; k < shadow_held; k++) begin
                step_out[n] = '{data: shadow_window[k], last: 1'b0};
                n = n + 1;
            end
            shift_window(shadow_held);
            if (n > 0) step_out[n-1].last = 1'b1;
        end
        return n;
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic fin,
                             input logic typed, input t_text_beat typed_beat);
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_text_byte  <= b;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent = beats_sent + 1;
        n = rewrite_step(b, fin);
        if (typed) begin
            expected_text.push_back(typed_beat);
        end else begin
            for (int k = 0; k < n; k++) expected_text.push_back(step_out[k]);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_text.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_PATTERN_LENGTH:    len_reg = data[LEN_REG_W-1:0];
            REG_PATTERN_BYTES:     pat_reg = data;
            REG_REPLACEMENT_BYTES: rep_reg = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // A string built from whole pattern copies, broken pattern prefixes and noise.
    task automatic send_text(input int segs);
        logic [BYTE_W-1:0] text [$];
        int                len;
        int                r;
        int                cut;
        len = active_length();
        for (int s = 0; s < segs; s++) begin
            r = $urandom_range(9);
            if (r < 6) begin
                for (int k = 0; k < len; k++) text.push_back(pat_reg[8*k +: 8]);
            end else if (r < 8) begin
                cut = $urandom_range(len - 1);
                for (int k = 0; k < cut; k++) text.push_back(pat_reg[8*k +: 8]);
                text.push_back(BYTE_W'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 3)) text.push_back(BYTE_W'($urandom_range(255)));
            end
        end
        for (int k = 0; k < text.size(); k++) begin
            send_beat(text[k], k == text.size() - 1, 1'b0, '0);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_trigger) begin
                hold_trigger = 1'b0;
                holding <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding <= 1'b0;
            end
        end
    end

    initial begin
        t_text_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_text.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: beat with none expected, got byte %02h last %0b",
                             $time, o_out_byte, o_out_last);
                end else begin
                    want = expected_text.pop_front();
                    if (o_out_byte !== want.data) begin
                        mismatches = mismatches + 1;
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.data, o_out_byte);
                    end
                    if (o_out_last !== want.last) begin
                        mismatches = mismatches + 1;
                        $display("%0t: out_last expected %0b, got %0b",
                                 $time, want.last, o_out_last);
                    end
                end
            end
            i_out_stall <= holding || ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        t_row                  row;
        logic [CFG_DATA_W-1:0] len_word;
        int                    phase_start;
        int                    phase_target;
        bit                    paused;
        clear_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_LEN; r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_WRITE) begin
                wait_drained();
                write_reg(row.idx, row.data);
            end else begin
                send_beat(row.text, row.fin, row.typed, '{data: row.exp_byte, last: row.exp_last});
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            len_word = {$urandom, $urandom};
            case (phase)
                0: len_word[LEN_REG_W-1:0] = LEN_REG_W'(1);
                1: len_word[LEN_REG_W-1:0] = LEN_REG_W'(WINDOW_DEPTH);
                2: len_word[LEN_REG_W-1:0] = '0;
                3: len_word[LEN_REG_W-1:0] = '1;
                default: len_word[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(1, WINDOW_DEPTH));
            endcase
            write_reg(REG_PATTERN_LENGTH, len_word);
            write_reg(REG_PATTERN_BYTES, {$urandom, $urandom});
            write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            if (phase == 5) write_reg(REG_UNMAPPED, {$urandom, $urandom});
            if (phase == PRESSURE_PHASE) hold_trigger = 1'b1;
            phase_target = (phase == PRESSURE_PHASE) ? PRESSURE_BEATS : PHASE_BEATS;
            phase_start = beats_sent;
            paused = 1'b0;
            while (beats_sent - phase_start < phase_target) begin
                send_text($urandom_range(1, 4));
                if (phase == PAUSE_PHASE && !paused
                        && beats_sent - phase_start >= phase_target / 2) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            // Half the time, leave an unfinished string so the next length write lands mid-string.
            if ($urandom_range(1)) begin
                repeat ($urandom_range(1, 3)) send_beat(BYTE_W'($urandom_range(255)), 1'b0,
                                                        1'b0, '0);
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
